// ===== design/brsp_pkg.sv =====
// Package for the banked ROM stream port: sizes, bus codes and fixed header values.
// Used by banked_rom_stream_port_unit and brsp_checker; depends on nothing.
package brsp_pkg;

    // Default ROM store depth in bytes
    localparam int ROM_DEPTH_DEF = 65536;

    // Field widths
    localparam int OP_W    = 2;
    localparam int PORT_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int LIDX_W  = 16;
    localparam int SIZE_W  = 17;
    localparam int IDX_W   = 17;
    localparam int REG_W   = 16;
    localparam int CFG_W   = 17;
    localparam int CFGI_W  = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    // Bus ports
    localparam logic [PORT_W-1:0] PORT_DATA_LO   = 4'd0;
    localparam logic [PORT_W-1:0] PORT_DATA_HI   = 4'd1;
    localparam logic [PORT_W-1:0] PORT_STAT_LO   = 4'd2;
    localparam logic [PORT_W-1:0] PORT_STAT_HI   = 4'd3;
    localparam logic [PORT_W-1:0] PORT_CTRL_LO   = 4'd4;
    localparam logic [PORT_W-1:0] PORT_CTRL_HI   = 4'd5;
    localparam logic [PORT_W-1:0] PORT_LO_STREAM = 4'd6;
    localparam logic [PORT_W-1:0] PORT_HI_STREAM = 4'd7;
    localparam logic [PORT_W-1:0] PORT_STAT_LO_A = 4'd8;
    localparam logic [PORT_W-1:0] PORT_STAT_HI_A = 4'd9;
    localparam logic [PORT_W-1:0] PORT_CTRL_LO_A = 4'd10;
    localparam logic [PORT_W-1:0] PORT_CTRL_HI_A = 4'd11;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_ROM_SIZE   = 1'b0;
    localparam logic [CFGI_W-1:0] CFG_FIRST_BANK = 1'b1;

    // Header steps
    localparam logic [1:0] HDR_IDLE = 2'd0;
    localparam logic [1:0] HDR_CODE = 2'd1;
    localparam logic [1:0] HDR_LEN  = 2'd2;

    // Register values and bank codes
    localparam logic [REG_W-1:0]  STATUS_RESET   = 16'hA00A;
    localparam logic [REG_W-1:0]  CTRL_TRIGGER   = 16'hA00A;
    localparam logic [REG_W-1:0]  BANK_FIRST     = 16'hCC00;
    localparam logic [REG_W-1:0]  BANK_SKIP_FROM = 16'hCC10;
    localparam logic [REG_W-1:0]  BANK_SKIP_TO   = 16'hCD00;
    localparam logic [BYTE_W-1:0] HDR_LEN_LO     = 8'hFA;
    localparam logic [BYTE_W-1:0] HDR_LEN_HI     = 8'h0F;

endpackage

// ===== design/brsp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module brsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/banked_rom_stream_port_unit.sv =====
// Top level of the banked ROM stream port: bus register file, stream indexes and ROM store.
// Depends on brsp_pkg and brsp_ram.
//
//  channel | signals                                   | direction | word
//  --------+-------------------------------------------+-----------+---------------------------
//  in      | i_in_valid / o_in_ready                   | to block  | operation, port, byte, idx
//  out     | o_out_valid / i_out_ready                 | from block| read_byte
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data         | to block  | rom_size, first_bank_start
//
// One word per cycle while the output does not stall. A word is decoded in the cycle it is
// accepted: registers, header step and stream indexes update then, and a stream read issues to
// the ROM store, whose registered read gives the byte in stage 1, then the output register.
// Reset (synchronous) clears control registers; the ROM store holds no reset. A stalled
// output holds stage 1 and then input.
module banked_rom_stream_port_unit #(
    parameter int ROM_DEPTH = brsp_pkg::ROM_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [brsp_pkg::OP_W-1:0]    i_operation,
    input  logic [brsp_pkg::PORT_W-1:0]  i_port,
    input  logic [brsp_pkg::BYTE_W-1:0]  i_write_byte,
    input  logic [brsp_pkg::LIDX_W-1:0]  i_load_index,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [brsp_pkg::BYTE_W-1:0]  o_read_byte,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [brsp_pkg::CFGI_W-1:0]  i_cfg_index,
    input  logic [brsp_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(ROM_DEPTH);

    // Configuration
    logic [brsp_pkg::SIZE_W-1:0] r_rom_size;
    logic [brsp_pkg::REG_W-1:0]  r_first_bank;

    // Bus state
    logic [brsp_pkg::REG_W-1:0]  r_status,  n_status;
    logic [brsp_pkg::REG_W-1:0]  r_control, n_control;
    logic [brsp_pkg::REG_W-1:0]  r_block,   n_block;
    logic [1:0]                  r_hdr,     n_hdr;
    logic [brsp_pkg::IDX_W-1:0]  r_low_idx, n_low_idx;
    logic [brsp_pkg::IDX_W-1:0]  r_high_idx, n_high_idx;

    // Stage 1 and output register
    logic                        r_s1_valid;
    logic                        r_s1_use_ram, n_s1_use_ram;
    logic [brsp_pkg::BYTE_W-1:0] r_s1_byte,    n_s1_byte;
    logic                        r_out_valid;
    logic [brsp_pkg::BYTE_W-1:0] r_out_byte;

    // Handshake
    logic in_accept;
    logic s1_advance;

    // Stream decode
    logic                        strm_rd;
    logic                        strm_high;
    logic [brsp_pkg::IDX_W-1:0]  strm_idx;
    logic [brsp_pkg::IDX_W:0]    strm_inc;
    logic                        strm_hit;
    logic                        strm_in_rom;
    logic [31:0]                 raddr_ext;
    logic [31:0]                 waddr_ext;
    logic [brsp_pkg::REG_W-1:0]  ctrl_hi_wr;
    logic [brsp_pkg::REG_W-1:0]  block_inc;

    // ROM port
    logic                        ram_we;
    logic                        ram_re;
    logic [brsp_pkg::BYTE_W-1:0] ram_rdata;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // Stream read selection on reads: ports 6/7 always, data ports only with no header armed
    assign strm_high = (i_port == brsp_pkg::PORT_HI_STREAM);
    assign strm_rd   = (i_operation == brsp_pkg::OP_READ) &&
                       ((i_port == brsp_pkg::PORT_LO_STREAM) || strm_high ||
                        (((i_port == brsp_pkg::PORT_DATA_LO) ||
                          (i_port == brsp_pkg::PORT_DATA_HI)) &&
                         (r_hdr == brsp_pkg::HDR_IDLE)));
    assign strm_idx    = strm_high ? r_high_idx : r_low_idx;
    assign strm_inc    = {1'b0, strm_idx} + {{brsp_pkg::IDX_W{1'b0}}, 1'b1};
    assign strm_hit    = strm_inc < {1'b0, r_rom_size};
    assign raddr_ext   = {{(32 - brsp_pkg::IDX_W){1'b0}}, strm_idx};
    assign strm_in_rom = raddr_ext < 32'(ROM_DEPTH);
    assign waddr_ext   = {{(32 - brsp_pkg::LIDX_W){1'b0}}, i_load_index};

    assign ram_re = in_accept && strm_rd && strm_hit && strm_in_rom;
    assign ram_we = in_accept && (i_operation == brsp_pkg::OP_LOAD) &&
                    (waddr_ext < 32'(ROM_DEPTH));

    assign ctrl_hi_wr = {i_write_byte, r_control[7:0]};
    assign block_inc  = r_block + 16'd1;

    // Decode of one word: next register state and the non-ROM result byte
    always_comb begin
        n_status     = r_status;
        n_control    = r_control;
        n_block      = r_block;
        n_hdr        = r_hdr;
        n_low_idx    = r_low_idx;
        n_high_idx   = r_high_idx;
        n_s1_use_ram = 1'b0;
        n_s1_byte    = '0;

        if (strm_rd) begin
            n_s1_use_ram = strm_hit && strm_in_rom;
            if (strm_hit) begin
                if (strm_high) begin
                    n_high_idx = strm_inc[brsp_pkg::IDX_W-1:0];
                end else begin
                    n_low_idx = strm_inc[brsp_pkg::IDX_W-1:0];
                end
            end
        end

        case (i_operation)
            brsp_pkg::OP_WRITE: begin
                case (i_port)
                    brsp_pkg::PORT_STAT_LO: n_status  = {r_status[15:8], i_write_byte};
                    brsp_pkg::PORT_STAT_HI: n_status  = {i_write_byte, r_status[7:0]};
                    brsp_pkg::PORT_CTRL_LO: n_control = {r_control[15:8], i_write_byte};
                    brsp_pkg::PORT_CTRL_HI: begin
                        n_control = ctrl_hi_wr;
                        // bank trigger
                        if (ctrl_hi_wr == brsp_pkg::CTRL_TRIGGER) begin
                            n_hdr = brsp_pkg::HDR_CODE;
                            if (r_block == '0) begin
                                n_block   = brsp_pkg::BANK_FIRST;
                                n_low_idx = {1'b0, r_first_bank};
                            end else if (block_inc == brsp_pkg::BANK_SKIP_FROM) begin
                                n_block = brsp_pkg::BANK_SKIP_TO;
                            end else begin
                                n_block = block_inc;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            brsp_pkg::OP_READ: begin
                case (i_port)
                    brsp_pkg::PORT_DATA_LO: begin
                        if (r_hdr == brsp_pkg::HDR_CODE) begin
                            n_s1_byte = r_block[7:0];
                        end else if (r_hdr == brsp_pkg::HDR_LEN) begin
                            n_s1_byte = brsp_pkg::HDR_LEN_LO;
                        end
                    end
                    brsp_pkg::PORT_DATA_HI: begin
                        if (r_hdr == brsp_pkg::HDR_CODE) begin
                            n_s1_byte = r_block[15:8];
                            n_hdr     = brsp_pkg::HDR_LEN;
                        end else if (r_hdr == brsp_pkg::HDR_LEN) begin
                            n_s1_byte = brsp_pkg::HDR_LEN_HI;
                            n_hdr     = brsp_pkg::HDR_IDLE;
                        end
                    end
                    brsp_pkg::PORT_STAT_LO,
                    brsp_pkg::PORT_STAT_LO_A: n_s1_byte = r_status[7:0];
                    brsp_pkg::PORT_STAT_HI,
                    brsp_pkg::PORT_STAT_HI_A: n_s1_byte = r_status[15:8];
                    brsp_pkg::PORT_CTRL_LO,
                    brsp_pkg::PORT_CTRL_LO_A: n_s1_byte = r_control[7:0];
                    brsp_pkg::PORT_CTRL_HI,
                    brsp_pkg::PORT_CTRL_HI_A: n_s1_byte = r_control[15:8];
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_size   <= '0;
            r_first_bank <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                brsp_pkg::CFG_ROM_SIZE:   r_rom_size   <= i_cfg_data;
                brsp_pkg::CFG_FIRST_BANK: r_first_bank <= i_cfg_data[brsp_pkg::REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Bus state updates on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= brsp_pkg::STATUS_RESET;
            r_control  <= '0;
            r_block    <= '0;
            r_hdr      <= brsp_pkg::HDR_IDLE;
            r_low_idx  <= '0;
            r_high_idx <= '0;
        end else if (in_accept) begin
            r_status   <= n_status;
            r_control  <= n_control;
            r_block    <= n_block;
            r_hdr      <= n_hdr;
            r_low_idx  <= n_low_idx;
            r_high_idx <= n_high_idx;
        end
    end

    // Stage 1: waits for the ROM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_use_ram <= n_s1_use_ram;
            r_s1_byte    <= n_s1_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_byte <= r_s1_use_ram ? ram_rdata : r_s1_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_out_byte;

    // ROM store; a load and a later read of the same entry are always separate words
    brsp_ram #(
        .WIDTH (brsp_pkg::BYTE_W),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_ext[AW-1:0]),
        .i_wdata (i_write_byte),
        .i_re    (ram_re),
        .i_raddr (raddr_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== design/brsp_checker.sv =====
// Port-level checks for banked_rom_stream_port_unit, bound to the top level.
// Depends on brsp_pkg.
module brsp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [brsp_pkg::BYTE_W-1:0]  o_read_byte
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // An empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its byte
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_read_byte))
        else $error("result byte changed while stalled");

endmodule

bind banked_rom_stream_port_unit brsp_checker u_brsp_checker (.*);

// ===== tb/sv/banked_rom_stream_port_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for banked_rom_stream_port_unit: directed table then phased random bus traffic,
// each result word checked in order against a local model. Depends on brsp_pkg and the RTL.
module banked_rom_stream_port_unit_tb;
    import brsp_pkg::*;

    // Codes the package leaves out: the spare operation and the unused port range
    localparam logic [OP_W-1:0]   OP_NONE         = 2'd3;
    localparam logic [PORT_W-1:0] PORT_SPARE      = 4'd12;
    localparam logic [PORT_W-1:0] PORT_SPARE_TOP  = 4'd15;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 80;

    // Per-phase idling (sender idle / receiver stall, percent) and register settings
    localparam int TX_IDLE  [4] = '{0, 52, 0, 30};
    localparam int RX_STALL [4] = '{0, 0, 52, 30};
    localparam int PH_ROM   [PHASES] = '{16, 0, 1, 65536, 90, 500, 65536, 40};
    localparam int PH_BANK  [PHASES] = '{0, 65535, 0, 1234, 65535, 7, 300, 0};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] wbyte;
        logic [LIDX_W-1:0] lidx;
        logic              typed;
        logic [BYTE_W-1:0] want;
    } t_bus_row;

    // Directed rows, run with rom_size 6 and the first bank at 3
    localparam int DIR_N = 27;
    localparam t_bus_row DIR_ROWS [DIR_N] = '{
        '{OP_READ,  PORT_STAT_LO,   8'h00, 16'h0000, 1'b1, STATUS_RESET[7:0]},
        '{OP_READ,  PORT_STAT_HI,   8'h00, 16'h0000, 1'b1, STATUS_RESET[15:8]},
        '{OP_READ,  PORT_CTRL_LO_A, 8'h00, 16'h0000, 1'b1, 8'h00},
        '{OP_READ,  PORT_SPARE,     8'h00, 16'h0000, 1'b1, 8'h00},
        '{OP_NONE,  PORT_CTRL_HI,   8'hFF, 16'hFFFF, 1'b1, 8'h00},
        '{OP_WRITE, PORT_STAT_LO,   8'hFF, 16'h0000, 1'b1, 8'h00},
        '{OP_READ,  PORT_STAT_LO_A, 8'h00, 16'h0000, 1'b1, 8'hFF},
        '{OP_WRITE, PORT_STAT_HI,   8'h00, 16'h0000, 1'b1, 8'h00},
        '{OP_READ,  PORT_STAT_HI_A, 8'h00, 16'h0000, 1'b1, 8'h00},
        '{OP_LOAD,  PORT_DATA_LO,   8'hFF, 16'hFFFF, 1'b1, 8'h00},
        '{OP_LOAD,  PORT_DATA_LO,   8'h00, 16'h0000, 1'b1, 8'h00},
        '{OP_READ,  PORT_HI_STREAM, 8'h00, 16'h0000, 1'b0, 8'h00},
        '{OP_WRITE, PORT_CTRL_LO,   CTRL_TRIGGER[7:0],  16'h0000, 1'b1, 8'h00},
        '{OP_WRITE, PORT_CTRL_HI,   CTRL_TRIGGER[15:8], 16'h0000, 1'b1, 8'h00},
        '{OP_READ,  PORT_DATA_LO,   8'h00, 16'h0000, 1'b1, BANK_FIRST[7:0]},
        '{OP_READ,  PORT_DATA_HI,   8'h00, 16'h0000, 1'b1, BANK_FIRST[15:8]},
        '{OP_READ,  PORT_DATA_LO,   8'h00, 16'h0000, 1'b1, HDR_LEN_LO},
        '{OP_READ,  PORT_DATA_HI,   8'h00, 16'h0000, 1'b1, HDR_LEN_HI},
        '{OP_READ,  PORT_DATA_LO,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{OP_READ,  PORT_DATA_HI,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{OP_READ,  PORT_LO_STREAM, 8'h00, 16'h0000, 1'b0, 8'h00},
        '{OP_WRITE, PORT_DATA_HI,   8'h55, 16'h0000, 1'b1, 8'h00},
        '{OP_WRITE, PORT_SPARE_TOP, 8'hFF, 16'h0000, 1'b1, 8'h00},
        '{OP_WRITE, PORT_CTRL_HI,   CTRL_TRIGGER[15:8], 16'h0000, 1'b1, 8'h00},
        '{OP_READ,  PORT_DATA_HI,   8'h00, 16'h0000, 1'b0, 8'h00},
        '{OP_READ,  PORT_DATA_LO,   8'h00, 16'h0000, 1'b1, HDR_LEN_LO},
        '{OP_READ,  PORT_DATA_HI,   8'h00, 16'h0000, 1'b1, HDR_LEN_HI}
    };

    // DUT ports
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_operation  = '0;
    logic [PORT_W-1:0]   i_port       = '0;
    logic [BYTE_W-1:0]   i_write_byte = '0;
    logic [LIDX_W-1:0]   i_load_index = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [BYTE_W-1:0]   o_read_byte;
    logic                i_cfg_we     = 1'b0;
    logic [CFGI_W-1:0]   i_cfg_index  = '0;
    logic [CFG_W-1:0]    i_cfg_data   = '0;

    banked_rom_stream_port_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_port       (i_port),
        .i_write_byte (i_write_byte),
        .i_load_index (i_load_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_byte  (o_read_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Model state of the port
    logic [BYTE_W-1:0] rom_img    [ROM_DEPTH_DEF];
    bit                rom_loaded [ROM_DEPTH_DEF];
    logic [SIZE_W-1:0] m_rom_size;
    logic [REG_W-1:0]  m_first_bank;
    logic [REG_W-1:0]  m_status;
    logic [REG_W-1:0]  m_control;
    logic [REG_W-1:0]  m_block;
    logic [1:0]        m_step;
    logic [IDX_W-1:0]  m_lo_idx;
    logic [IDX_W-1:0]  m_hi_idx;

    logic [BYTE_W-1:0] pending_bytes [$];
    logic [BYTE_W-1:0] got_want;

    int err_count     = 0;
    int cycle_cnt     = 0;
    int n_words       = 0;
    int n_fills       = 0;
    int n_checked     = 0;
    int n_triggers    = 0;
    int n_fetched     = 0;
    int phase_items   = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    // Fetch the next byte of one stream; the index moves only below rom_size - 1
    function automatic logic [BYTE_W-1:0] stream_next(input bit use_hi);
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] r;
        idx = use_hi ? m_hi_idx : m_lo_idx;
        r   = '0;
        if ({1'b0, idx} + 18'd1 < {1'b0, m_rom_size}) begin
            if (!idx[IDX_W-1])
                r = rom_img[idx[LIDX_W-1:0]];
            idx = idx + 1'b1;
            n_fetched++;
        end
        if (use_hi)
            m_hi_idx = idx;
        else
            m_lo_idx = idx;
        return r;
    endfunction

    // Control register reached the trigger value: start or step the block code
    function automatic void advance_bank();
        if (m_block == '0) begin
            m_block  = BANK_FIRST;
            m_lo_idx = {1'b0, m_first_bank};
        end else begin
            m_block = m_block + 1'b1;
            if (m_block == BANK_SKIP_FROM)
                m_block = BANK_SKIP_TO;
        end
        m_step = HDR_CODE;
        n_triggers++;
    endfunction

    // Apply one word to the model and return the byte the port answers
    function automatic logic [BYTE_W-1:0] port_answer(input logic [OP_W-1:0] op,
                                                      input logic [PORT_W-1:0] port,
                                                      input logic [BYTE_W-1:0] wb,
                                                      input logic [LIDX_W-1:0] li);
        logic [BYTE_W-1:0] r;
        r = '0;
        case (op)
            OP_WRITE: begin
                case (port)
                    PORT_STAT_LO: m_status[7:0]   = wb;
                    PORT_STAT_HI: m_status[15:8]  = wb;
                    PORT_CTRL_LO: m_control[7:0]  = wb;
                    PORT_CTRL_HI: begin
                        m_control[15:8] = wb;
                        if (m_control == CTRL_TRIGGER)
                            advance_bank();
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                case (port)
                    PORT_DATA_LO: begin
                        if (m_step == HDR_CODE)
                            r = m_block[7:0];
                        else if (m_step == HDR_LEN)
                            r = HDR_LEN_LO;
                        else
                            r = stream_next(1'b0);
                    end
                    PORT_DATA_HI: begin
                        if (m_step == HDR_CODE) begin
                            r      = m_block[15:8];
                            m_step = HDR_LEN;
                        end else if (m_step == HDR_LEN) begin
                            r      = HDR_LEN_HI;
                            m_step = HDR_IDLE;
                        end else begin
                            r = stream_next(1'b0);
                        end
                    end
                    PORT_STAT_LO, PORT_STAT_LO_A: r = m_status[7:0];
                    PORT_STAT_HI, PORT_STAT_HI_A: r = m_status[15:8];
                    PORT_CTRL_LO, PORT_CTRL_LO_A: r = m_control[7:0];
                    PORT_CTRL_HI, PORT_CTRL_HI_A: r = m_control[15:8];
                    PORT_LO_STREAM: r = stream_next(1'b0);
                    PORT_HI_STREAM: r = stream_next(1'b1);
                    default: r = '0;
                endcase
            end
            OP_LOAD: begin
                rom_img[li]    = wb;
                rom_loaded[li] = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // True when the word would fetch a ROM byte that was never loaded
    function automatic bit hits_unloaded(input logic [OP_W-1:0] op,
                                         input logic [PORT_W-1:0] port,
                                         output logic [LIDX_W-1:0] at);
        logic [IDX_W-1:0] idx;
        bit               fetch;
        fetch = 1'b0;
        idx   = m_lo_idx;
        if (op == OP_READ) begin
            if (port == PORT_LO_STREAM ||
                ((port == PORT_DATA_LO || port == PORT_DATA_HI) && m_step == HDR_IDLE))
                fetch = 1'b1;
            else if (port == PORT_HI_STREAM) begin
                fetch = 1'b1;
                idx   = m_hi_idx;
            end
        end
        at = idx[LIDX_W-1:0];
        return fetch && ({1'b0, idx} + 18'd1 < {1'b0, m_rom_size}) && !idx[IDX_W-1] &&
               !rom_loaded[idx[LIDX_W-1:0]];
    endfunction

    // Offer one word on the input channel, called and returning at a falling edge
    task automatic offer(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                         input logic [BYTE_W-1:0] wb, input logic [LIDX_W-1:0] li,
                         input logic typed, input logic [BYTE_W-1:0] want);
        logic [BYTE_W-1:0] answer;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        answer = port_answer(op, port, wb, li);
        pending_bytes.insert(pending_bytes.size(), typed ? want : answer);
        i_operation  = op;
        i_port       = port;
        i_write_byte = wb;
        i_load_index = li;
        i_in_valid   = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        n_words++;
        @(negedge i_clk);
    endtask

    // Send a word, first loading the ROM byte it would fetch if still unwritten
    task automatic send(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                        input logic [BYTE_W-1:0] wb, input logic [LIDX_W-1:0] li,
                        input logic typed, input logic [BYTE_W-1:0] want);
        logic [LIDX_W-1:0] at;
        if (hits_unloaded(op, port, at)) begin
            offer(OP_LOAD, PORT_DATA_LO, 8'($urandom), at, 1'b0, 8'h00);
            n_fills++;
        end
        offer(op, port, wb, li, typed, want);
        phase_items++;
    endtask

    task automatic send_rand(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                             input logic [BYTE_W-1:0] wb);
        send(op, port, wb, 16'($urandom), 1'b0, 8'h00);
    endtask

    // One random sequence: bank trigger with header, stream reads, registers, loads, noise
    task automatic random_burst();
        logic [PORT_W-1:0] data_ports [4];
        logic [LIDX_W-1:0] base;
        logic [BYTE_W-1:0] hi_byte;
        int kind;
        int n;
        data_ports = '{PORT_DATA_LO, PORT_DATA_HI, PORT_LO_STREAM, PORT_HI_STREAM};
        kind = $urandom_range(99);
        if (kind < 25) begin
            hi_byte = ($urandom_range(9) == 0) ? 8'($urandom) : CTRL_TRIGGER[15:8];
            send_rand(OP_WRITE, PORT_CTRL_LO, CTRL_TRIGGER[7:0]);
            send_rand(OP_WRITE, PORT_CTRL_HI, hi_byte);
            n = $urandom_range(5, 1);
            repeat (n)
                send_rand(OP_READ, $urandom_range(1) ? PORT_DATA_HI : PORT_DATA_LO, 8'h00);
            n = $urandom_range(4);
            repeat (n)
                send_rand(OP_READ, data_ports[$urandom_range(3)], 8'h00);
        end else if (kind < 55) begin
            n = $urandom_range(8, 1);
            repeat (n)
                send_rand(OP_READ, data_ports[$urandom_range(3)], 8'($urandom));
        end else if (kind < 70) begin
            n = $urandom_range(4, 1);
            repeat (n) begin
                if ($urandom_range(1))
                    send_rand(OP_WRITE, 4'($urandom_range(PORT_CTRL_HI, PORT_STAT_LO)),
                              8'($urandom));
                else
                    send_rand(OP_READ, 4'($urandom_range(PORT_CTRL_HI_A, PORT_STAT_LO)),
                              8'($urandom));
            end
        end else if (kind < 85) begin
            // preload ahead of a stream so reads land on bytes written here
            case ($urandom_range(2))
                0: base = m_lo_idx[LIDX_W-1:0];
                1: base = m_hi_idx[LIDX_W-1:0];
                default: base = 16'($urandom);
            endcase
            n = $urandom_range(6, 1);
            for (int k = 0; k < n; k++)
                send(OP_LOAD, 4'($urandom), 8'($urandom), base + 16'(k), 1'b0, 8'h00);
        end else begin
            send(2'($urandom), 4'($urandom), 8'($urandom), 16'($urandom), 1'b0, 8'h00);
        end
    endtask

    // Wait until every expected word has come back, then let the pipe settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        i_in_valid = 1'b0;
        while (pending_bytes.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_bytes.size() != 0) begin
            $error("read_byte: %0d expected words never arrived", pending_bytes.size());
            err_count++;
            pending_bytes.delete();
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx == CFG_ROM_SIZE)
            m_rom_size = val;
        else
            m_first_bank = val[REG_W-1:0];
    endtask

    // Receiver: random stalls, plus long hold-offs counted here on request
    always @(negedge i_clk) begin
        if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker: compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                $error("read_byte: word with nothing expected, got %02h", o_read_byte);
                err_count++;
            end else begin
                got_want = pending_bytes.pop_front();
                n_checked++;
                if (o_read_byte !== got_want) begin
                    $error("read_byte: expected %02h, got %02h", got_want, o_read_byte);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk)
        cycle_cnt++;

    initial begin
        wait (cycle_cnt >= TIMEOUT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        m_rom_size   = '0;
        m_first_bank = '0;
        m_status     = STATUS_RESET;
        m_control    = '0;
        m_block      = '0;
        m_step       = HDR_IDLE;
        m_lo_idx     = '0;
        m_hi_idx     = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        write_cfg(CFG_ROM_SIZE, 17'd6);
        write_cfg(CFG_FIRST_BANK, 17'd3);
        for (int r = 0; r < DIR_N; r++)
            send(DIR_ROWS[r].op, DIR_ROWS[r].port, DIR_ROWS[r].wbyte, DIR_ROWS[r].lidx,
                 DIR_ROWS[r].typed, DIR_ROWS[r].want);
        wait_drained();

        // random phases, each with its own settings and idling
        for (int p = 0; p < PHASES; p++) begin
            write_cfg(CFG_ROM_SIZE, 17'(PH_ROM[p]));
            write_cfg(CFG_FIRST_BANK, 17'(PH_BANK[p]));
            tx_idle_pct  = TX_IDLE[p % 4];
            rx_stall_pct = RX_STALL[p % 4];
            phase_items  = 0;
            while (phase_items < PHASE_ITEMS) begin
                // long receiver hold-off mid-phase while words keep coming
                if (p % 4 == 0 && phase_items >= 40 && hold_requests == p / 4)
                    hold_requests++;
                random_burst();
            end
            wait_drained();
        end

        $display("Covered %0d bus words (%0d ROM fills ahead of reads), %0d result words checked.",
                 n_words, n_fills, n_checked);
        $display("Bank triggers %0d up to block code %04h, %0d stream bytes fetched, %0d phases.",
                 n_triggers, m_block, n_fetched, PHASES + 1);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
